// ===== rtl/tdpt_pkg.sv =====
// shared types and constants for the trial division prime test
package tdpt_pkg;

    // first divisor of the 6k-1 / 6k+1 wheel
    localparam int unsigned C_FIRST_DIV = 5;
    // distance from one 6k-1 divisor to the next
    localparam int unsigned C_WHEEL_STEP = 6;
    // distance from 6k-1 to 6k+1
    localparam int unsigned C_PAIR_GAP = 2;
    // small divisor tried before the wheel starts
    localparam int unsigned C_THREE = 3;
    // largest candidate that is neither tested nor prime
    localparam int unsigned C_LAST_NON_PRIME = 1;
    // largest small prime
    localparam int unsigned C_LAST_SMALL_PRIME = 3;

    // which divisor is in flight
    typedef enum logic [1:0] {
        K_THREE,
        K_LO,
        K_HI
    } t_div_kind;

endpackage

// ===== rtl/trial_division_prime_test_core.sv =====
// trial division prime test core with a bit-serial remainder unit
//
// Input channel: i_valid / o_stall carry one request, the WIDTH-bit i_candidate.
// Output channel: o_valid / i_stall carry one result, o_prime_flag.
// A request is taken at a rising edge with i_valid high and o_stall low.
// Candidates 0..3 and even candidates skip the divider and go via S_FINISH to the output.
// Otherwise the core divides by 3, then by d and d+2 for d = 5, 11, 17, ...
// while d <= candidate / d. Each division runs through a restoring radix-2
// divider that shifts one quotient bit per cycle in S_DIV, followed by a check of
// remainder and bound in S_CHECK. The divider loop sets the run time.
// One request is worked on at a time. The result sits in an output register;
// while the receiver stalls it, the core can already take the next request
// and starts it at once, holding its own result until the register frees up.
// Synchronous active-low reset returns the core to idle and drops o_valid.
module trial_division_prime_test_core
    import tdpt_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_candidate,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_prime_flag
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    t_div_kind        r_kind, n_kind;
    logic [WIDTH-1:0] r_n, n_n;
    logic [WIDTH-1:0] r_div, n_div;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_sh, n_sh;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic             r_out_prime, n_out_prime;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   rem_sub;
    logic             rem_ge;
    logic             out_free;

    assign rem_sh   = {r_rem, r_sh[WIDTH-1]};
    assign rem_sub  = rem_sh - {1'b0, r_div};
    assign rem_ge   = rem_sh >= {1'b0, r_div};
    assign out_free = !r_out_valid || !i_stall;

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_prime_flag = r_out_prime;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_n         = r_n;
        n_div       = r_div;
        n_rem       = r_rem;
        n_sh        = r_sh;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_prime = r_out_prime;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_n = i_candidate;
                    if (i_candidate <= WIDTH'(C_LAST_NON_PRIME)) begin
                        n_res   = 1'b0;
                        n_state = S_FINISH;
                    end else if (i_candidate <= WIDTH'(C_LAST_SMALL_PRIME)) begin
                        n_res   = 1'b1;
                        n_state = S_FINISH;
                    end else if (!i_candidate[0]) begin
                        n_res   = 1'b0;
                        n_state = S_FINISH;
                    end else begin
                        n_div   = WIDTH'(C_THREE);
                        n_kind  = K_THREE;
                        n_rem   = '0;
                        n_sh    = i_candidate;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // one quotient bit per cycle, quotient shifts in behind the dividend
                n_rem = rem_ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
                n_sh  = {r_sh[WIDTH-2:0], rem_ge};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == LAST_BIT) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_rem = '0;
                n_sh  = r_n;
                n_cnt = '0;
                case (r_kind)
                    K_THREE: begin
                        if (r_rem == '0) begin
                            n_res   = 1'b0;
                            n_state = S_FINISH;
                        end else begin
                            n_div   = WIDTH'(C_FIRST_DIV);
                            n_kind  = K_LO;
                            n_state = S_DIV;
                        end
                    end
                    K_LO: begin
                        // r_sh holds n / d here: stop once d > n / d
                        if (r_div > r_sh) begin
                            n_res   = 1'b1;
                            n_state = S_FINISH;
                        end else if (r_rem == '0) begin
                            n_res   = 1'b0;
                            n_state = S_FINISH;
                        end else begin
                            n_div   = r_div + WIDTH'(C_PAIR_GAP);
                            n_kind  = K_HI;
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        if (r_rem == '0) begin
                            n_res   = 1'b0;
                            n_state = S_FINISH;
                        end else begin
                            n_div   = r_div + WIDTH'(C_WHEEL_STEP - C_PAIR_GAP);
                            n_kind  = K_LO;
                            n_state = S_DIV;
                        end
                    end
                endcase
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_kind      <= n_kind;
        r_n         <= n_n;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_sh        <= n_sh;
        r_cnt       <= n_cnt;
        r_res       <= n_res;
        r_out_prime <= n_out_prime;
    end

    // partial remainder never reaches the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    // every divisor tried is odd
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_div[0])
        else $error("even divisor in flight");

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("request accepted but core stayed idle");

    // a result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out_prime)))
        else $error("pending result overwritten");

endmodule
